>>> rtl/matrix_multiply_unit_macros.svh
// assertion macros shared by the matrix multiply unit
`ifndef MATRIX_MULTIPLY_UNIT_MACROS_SVH
`define MATRIX_MULTIPLY_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define MMU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define MMU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mmu_pkg.sv
// types, constants and helpers of the matrix multiply unit
package mmu_pkg;

  localparam int unsigned MAX_DIM   = 64;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_RESET = 64;
  localparam int unsigned Q_FRAC    = 16;

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned SIZE_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CMP_W  = (SIZE_W > IDX_W) ? SIZE_W + 1 : IDX_W + 1;
  localparam int unsigned LIN_W  = ADDR_W + CMP_W;
  localparam int unsigned PROD_W = 2 * OUT_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int unsigned FIT_MSB = OUT_W + Q_FRAC - 1;

  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE_A = 2'd0,
    MODE_WRITE_B = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS  = 2'd0,
    CFG_INNER = 2'd1,
    CFG_COLS  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctl_t;

  typedef struct packed {
    logic                    busy;
    logic                    saturated;
    logic signed [OUT_W-1:0] product;
  } mac_res_t;

  // register value clamped to the largest dimension
  function automatic logic [CMP_W-1:0] eff_size(input logic [CFG_W-1:0] r);
    logic [CMP_W-1:0] v;
    v = CMP_W'(r);
    if (v > CMP_W'(MAX_DIM)) begin
      v = CMP_W'(MAX_DIM);
    end
    return v;
  endfunction

  // row-major word address of an element
  function automatic logic [ADDR_W-1:0] addr_of(input logic [CMP_W-1:0] r,
                                                input logic [CMP_W-1:0] c);
    logic [LIN_W-1:0] lin;
    lin = LIN_W'(r) * LIN_W'(MAX_DIM) + LIN_W'(c);
    return lin[ADDR_W-1:0];
  endfunction

endpackage

>>> rtl/mmu_ram.sv
// generic single-port-write, single-port-read ram with registered read
module mmu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mmu_mac.sv
// multiply-accumulate datapath with q16.16 truncation and saturation
module mmu_mac (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mmu_pkg::mac_ctl_t           ctl_i,
  input  logic [mmu_pkg::OUT_W-1:0]   a_i,
  input  logic [mmu_pkg::OUT_W-1:0]   b_i,
  output mmu_pkg::mac_res_t           res_o
);
  import mmu_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_v_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     fits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctl_i.valid & ~ctl_i.clear;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prod_q <= $signed(a_i) * $signed(b_i);
    end
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // sum fits when everything above the kept window is pure sign
  assign fits = (&acc_q[ACC_W-1:FIT_MSB]) | ~(|acc_q[ACC_W-1:FIT_MSB]);

  always_comb begin
    res_o.busy      = prod_v_q;
    res_o.saturated = ~fits;
    if (fits) begin
      res_o.product = acc_q[FIT_MSB:Q_FRAC];
    end else if (acc_q[ACC_W-1]) begin
      res_o.product = SAT_MIN;
    end else begin
      res_o.product = SAT_MAX;
    end
  end

endmodule

>>> rtl/matrix_multiply_unit.sv
// matrix multiply unit: two element memories, sequencer and result register
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o   mode, row, col, value
//   out      source     out_valid_o/out_stall_i product, index_error, saturated
//   cfg      sink       cfg_valid_i/cfg_ready_o index, data
//
// a write word goes straight into its memory; a compute word reads one element
// pair a cycle from the two memories into the mac, inner_q pairs held to 64 (none with
// inner zero), and its result goes through the emit state to the output register. an
// index error word goes to the emit state directly. reset clears control and sets all
// sizes to 64; memories keep no reset. a stalled result sits in the output register
// while the next word is taken and worked on.
module matrix_multiply_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mmu_pkg::MODE_W-1:0]    in_mode_i,
  input  logic [mmu_pkg::IDX_W-1:0]     in_row_i,
  input  logic [mmu_pkg::IDX_W-1:0]     in_col_i,
  input  logic signed [mmu_pkg::OUT_W-1:0] in_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [mmu_pkg::OUT_W-1:0] out_product_o,
  output logic                          out_index_error_o,
  output logic                          out_saturated_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mmu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mmu_pkg::CFG_W-1:0]     cfg_data_i
);
  import mmu_pkg::*;

`include "matrix_multiply_unit_macros.svh"

  state_e state_q, state_d;

  logic [CFG_W-1:0] rows_q, inner_q, cols_q;
  logic [CMP_W-1:0] nr_eff, nk_eff, nc_eff;
  logic [CMP_W-1:0] row_in, col_in;
  logic [CMP_W-1:0] row_q, row_d, col_q, col_d, k_q, k_d;
  logic             err_q, err_d;
  logic             rd_v_q;
  logic             in_acc, issue, out_load;
  logic             a_we, b_we;
  logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr;
  logic [OUT_W-1:0]  a_rdata, b_rdata;
  mac_ctl_t          mac_ctl;
  mac_res_t          mac_res;

  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_product_q;
  logic                    out_err_q, out_sat_q;

  assign nr_eff = eff_size(rows_q);
  assign nk_eff = eff_size(inner_q);
  assign nc_eff = eff_size(cols_q);
  assign row_in = CMP_W'(in_row_i);
  assign col_in = CMP_W'(in_col_i);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CFG_W'(CFG_RESET);
      inner_q <= CFG_W'(CFG_RESET);
      cols_q  <= CFG_W'(CFG_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ROWS:  rows_q  <= cfg_data_i;
        CFG_INNER: inner_q <= cfg_data_i;
        CFG_COLS:  cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      err_q   <= 1'b0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      err_q   <= err_d;
      rd_v_q  <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
  end

  always_comb begin
    state_d       = state_q;
    k_d           = k_q;
    err_d         = err_q;
    row_d         = row_q;
    col_d         = col_q;
    a_we          = 1'b0;
    b_we          = 1'b0;
    issue         = 1'b0;
    out_load      = 1'b0;
    mac_ctl.clear = 1'b0;
    mac_ctl.valid = rd_v_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (mode_e'(in_mode_i))
            MODE_WRITE_A: begin
              if (row_in >= nr_eff || col_in >= nk_eff) begin
                err_d   = 1'b1;
                state_d = ST_EMIT;
              end else begin
                a_we = 1'b1;
              end
            end
            MODE_WRITE_B: begin
              if (row_in >= nk_eff || col_in >= nc_eff) begin
                err_d   = 1'b1;
                state_d = ST_EMIT;
              end else begin
                b_we = 1'b1;
              end
            end
            MODE_COMPUTE: begin
              if (row_in >= nr_eff || col_in >= nc_eff) begin
                err_d   = 1'b1;
                state_d = ST_EMIT;
              end else begin
                err_d         = 1'b0;
                k_d           = '0;
                row_d         = row_in;
                col_d         = col_in;
                mac_ctl.clear = 1'b1;
                state_d       = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (k_q < nk_eff) begin
          issue = 1'b1;
          k_d   = k_q + CMP_W'(1);
        end else if (!rd_v_q && !mac_res.busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign wr_addr = addr_of(row_in, col_in);
  assign a_raddr = addr_of(row_q, k_q);
  assign b_raddr = addr_of(k_q, col_q);

  mmu_ram #(
    .Width(OUT_W),
    .Depth(DEPTH)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(wr_addr),
    .wdata_i(in_value_i),
    .re_i   (issue),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  mmu_ram #(
    .Width(OUT_W),
    .Depth(DEPTH)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(wr_addr),
    .wdata_i(in_value_i),
    .re_i   (issue),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  mmu_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mac_ctl),
    .a_i   (a_rdata),
    .b_i   (b_rdata),
    .res_o (mac_res)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_product_q <= err_q ? '0 : mac_res.product;
      out_sat_q     <= ~err_q & mac_res.saturated;
      out_err_q     <= err_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_product_o     = out_product_q;
  assign out_index_error_o = out_err_q;
  assign out_saturated_o   = out_sat_q;

  `MMU_ASSERT_IMPL(a_k_bound, state_q == ST_RUN, k_q <= nk_eff, "inner counter overran")
  `MMU_ASSERT_IMPL(a_no_rw_mix, a_we || b_we, !issue, "memory write during compute read")
  `MMU_ASSERT_IMPL(a_drained, state_q == ST_RUN && state_d == ST_EMIT, !rd_v_q && !mac_res.busy, "result taken before mac drained")
  `MMU_ASSERT_IMPL(a_err_word, out_valid_o && out_index_error_o, out_product_o == '0 && !out_saturated_o, "error word carries data")
  `MMU_ASSERT_NEXT(a_load_valid, out_load, out_valid_q, "loaded word not presented")

endmodule

>>> tb/matrix_multiply_unit_tb.sv
// self-checking testbench of the matrix multiply unit: directed table, then random loads and products
module matrix_multiply_unit_tb;
  import mmu_pkg::*;

  localparam logic [MODE_W-1:0]    MODE_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
  localparam int unsigned          RANDOM_WORDS = 1000;
  localparam int unsigned          SETTLE_CYCLES = 16;
  localparam int unsigned          DRAIN_CYCLES = 100;
  localparam int unsigned          STALL_LIMIT  = 2000;

  typedef struct packed {
    logic signed [OUT_W-1:0] product;
    logic                    index_error;
    logic                    saturated;
  } gemm_result_t;

  typedef enum logic {
    ROW_SIZES,
    ROW_WORD
  } dir_kind_e;

  typedef struct {
    dir_kind_e               kind;
    logic [MODE_W-1:0]       mode;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [OUT_W-1:0] value;
    logic [CFG_W-1:0]        rows;
    logic [CFG_W-1:0]        inner;
    logic [CFG_W-1:0]        cols;
    bit                      typed;
    gemm_result_t            want;
  } dir_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [MODE_W-1:0]       in_mode_i = '0;
  logic [IDX_W-1:0]        in_row_i = '0;
  logic [IDX_W-1:0]        in_col_i = '0;
  logic signed [OUT_W-1:0] in_value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] out_product_o;
  logic                    out_index_error_o;
  logic                    out_saturated_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_W-1:0]        cfg_data_i = '0;

  // own copy of the block state
  logic signed [OUT_W-1:0] mat_a [DEPTH];
  logic signed [OUT_W-1:0] mat_b [DEPTH];
  bit                      a_loaded [DEPTH];
  bit                      b_loaded [DEPTH];
  logic [CFG_W-1:0]        rows_sz = CFG_W'(CFG_RESET);
  logic [CFG_W-1:0]        inner_sz = CFG_W'(CFG_RESET);
  logic [CFG_W-1:0]        cols_sz = CFG_W'(CFG_RESET);

  gemm_result_t pending_results [$];
  bit           sender_steady = 1'b0;
  int unsigned  words_sent = 0;
  int unsigned  results_checked = 0;
  int unsigned  sat_seen = 0;
  int unsigned  err_seen = 0;
  int unsigned  size_writes = 0;
  int unsigned  fail_count = 0;
  int unsigned  idle_cycles = 0;

  matrix_multiply_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_mode_i         (in_mode_i),
    .in_row_i          (in_row_i),
    .in_col_i          (in_col_i),
    .in_value_i        (in_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_product_o     (out_product_o),
    .out_index_error_o (out_index_error_o),
    .out_saturated_o   (out_saturated_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [CFG_W-1:0] dim_limit(input logic [CFG_W-1:0] v);
    return (v > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : v;
  endfunction

  function automatic gemm_result_t make_result(input logic signed [OUT_W-1:0] p,
                                               input logic e, input logic s);
    gemm_result_t r;
    r.product = p;
    r.index_error = e;
    r.saturated = s;
    return r;
  endfunction

  // updates the stored matrices and returns 1 when the word gives a result
  function automatic bit predict_gemm(input logic [MODE_W-1:0] mode,
                                      input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                                      input logic signed [OUT_W-1:0] value,
                                      output gemm_result_t res);
    logic [CFG_W-1:0]       nr;
    logic [CFG_W-1:0]       nk;
    logic [CFG_W-1:0]       nc;
    logic signed [127:0]    acc;
    logic signed [63:0]     a;
    logic signed [63:0]     b;
    logic signed [63:0]     p;
    nr = dim_limit(rows_sz);
    nk = dim_limit(inner_sz);
    nc = dim_limit(cols_sz);
    res = make_result('0, 1'b1, 1'b0);
    case (mode)
      MODE_WRITE_A: begin
        if (row >= nr || col >= nk) return 1'b1;
        mat_a[{row, col}] = value;
        a_loaded[{row, col}] = 1'b1;
        return 1'b0;
      end
      MODE_WRITE_B: begin
        if (row >= nk || col >= nc) return 1'b1;
        mat_b[{row, col}] = value;
        b_loaded[{row, col}] = 1'b1;
        return 1'b0;
      end
      MODE_COMPUTE: begin
        if (row >= nr || col >= nc) return 1'b1;
        acc = '0;
        for (int k = 0; k < nk; k++) begin
          a = mat_a[{row, IDX_W'(k)}];
          b = mat_b[{IDX_W'(k), col}];
          p = a * b;
          acc = acc + p;
        end
        // q32.32 sum fits q16.16 when bits 127..47 are all equal
        if ((acc[127:47] == '0) || (&acc[127:47])) begin
          res = make_result(acc[47:16], 1'b0, 1'b0);
        end else begin
          res = make_result(acc[127] ? SAT_MIN : SAT_MAX, 1'b0, 1'b1);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic signed [OUT_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return '0;
      3: return $urandom;
      default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_big();
    return ($urandom_range(0, 1) == 0) ? CFG_W'(MAX_DIM) : CFG_W'($urandom_range(65, 127));
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic dir_row_t sizes_row(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
                                         input logic [CFG_W-1:0] c);
    dir_row_t d;
    d = '{kind: ROW_SIZES, mode: '0, row: '0, col: '0, value: '0, rows: r, inner: k,
          cols: c, typed: 1'b0, want: '0};
    return d;
  endfunction

  function automatic dir_row_t word_row(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] r,
                                        input logic [IDX_W-1:0] c,
                                        input logic signed [OUT_W-1:0] v);
    dir_row_t d;
    d = '{kind: ROW_WORD, mode: m, row: r, col: c, value: v, rows: '0, inner: '0, cols: '0,
          typed: 1'b0, want: '0};
    return d;
  endfunction

  function automatic dir_row_t typed_row(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] r,
                                         input logic [IDX_W-1:0] c,
                                         input logic signed [OUT_W-1:0] v,
                                         input gemm_result_t w);
    dir_row_t d;
    d = word_row(m, r, c, v);
    d.typed = 1'b1;
    d.want = w;
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    fail_count++;
  endtask

  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic signed [OUT_W-1:0] value,
                           input bit typed, input gemm_result_t want);
    gemm_result_t pred;
    int unsigned  gap;
    in_valid_i <= 1'b1;
    in_mode_i <= mode;
    in_row_i <= row;
    in_col_i <= col;
    in_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_gemm(mode, row, col, value, pred)) begin
      pending_results.push_back(typed ? want : pred);
    end
    if (mode != MODE_SPARE) words_sent++;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // loads any operand the product would read before it was written
  task automatic request_product(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
    logic [CFG_W-1:0] nk;
    if (row < dim_limit(rows_sz) && col < dim_limit(cols_sz)) begin
      nk = dim_limit(inner_sz);
      for (int k = 0; k < nk; k++) begin
        if (!a_loaded[{row, IDX_W'(k)}]) begin
          send_word(MODE_WRITE_A, row, IDX_W'(k), pick_value(), 1'b0, '0);
        end
        if (!b_loaded[{IDX_W'(k), col}]) begin
          send_word(MODE_WRITE_B, IDX_W'(k), col, pick_value(), 1'b0, '0);
        end
      end
    end
    send_word(MODE_COMPUTE, row, col, $urandom, 1'b0, '0);
  endtask

  // leaves cfg_valid_i high so writes can go back to back
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ROWS:  rows_sz = data;
      CFG_INNER: inner_sz = data;
      CFG_COLS:  cols_sz = data;
      default: ;
    endcase
    size_writes++;
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
                           input logic [CFG_W-1:0] c);
    cfg_write(CFG_ROWS, r);
    cfg_write(CFG_INNER, k);
    cfg_write(CFG_COLS, c);
    cfg_valid_i <= 1'b0;
  endtask

  // a write word may still be in flight after the last result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stall_pattern
    int unsigned n;
    forever begin
      if ($urandom_range(0, 19) == 0) n = $urandom_range(100, 300);
      else n = $urandom_range(1, 12);
      out_stall_i <= 1'b0;
      repeat (n) @(posedge clk_i);
      n = pick_gap();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    gemm_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none pending", out_product_o, '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.saturated) sat_seen++;
        if (want.index_error) err_seen++;
        if (out_product_o !== want.product) begin
          report_mismatch("product", out_product_o, want.product);
        end
        if (out_index_error_o !== want.index_error) begin
          report_mismatch("index_error", OUT_W'(out_index_error_o), OUT_W'(want.index_error));
        end
        if (out_saturated_o !== want.saturated) begin
          report_mismatch("saturated", OUT_W'(out_saturated_o), OUT_W'(want.saturated));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    dir_row_t          dir_table [$];
    logic [CFG_W-1:0]  r;
    logic [CFG_W-1:0]  k;
    logic [CFG_W-1:0]  c;
    logic [CFG_W-1:0]  nr;
    logic [CFG_W-1:0]  nk;
    logic [CFG_W-1:0]  nc;
    logic [MODE_W-1:0] m;
    int unsigned       pick;
    int unsigned       actions;
    int unsigned       phase;
    int unsigned       sel;
    bit                big;

    dir_table.push_back(sizes_row(7'd2, 7'd2, 7'd2));
    dir_table.push_back(word_row(MODE_WRITE_A, 6'd0, 6'd0, SAT_MAX));
    dir_table.push_back(word_row(MODE_WRITE_A, 6'd0, 6'd1, '0));
    dir_table.push_back(word_row(MODE_WRITE_B, 6'd0, 6'd0, SAT_MAX));
    dir_table.push_back(word_row(MODE_WRITE_B, 6'd1, 6'd0, '0));
    dir_table.push_back(typed_row(MODE_COMPUTE, 6'd0, 6'd0, SAT_MAX,
                                  make_result(SAT_MAX, 1'b0, 1'b1)));
    dir_table.push_back(word_row(MODE_WRITE_A, 6'd0, 6'd0, SAT_MIN));
    dir_table.push_back(typed_row(MODE_COMPUTE, 6'd0, 6'd0, '0,
                                  make_result(SAT_MIN, 1'b0, 1'b1)));
    // min times min is positive and overflows
    dir_table.push_back(word_row(MODE_WRITE_B, 6'd0, 6'd0, SAT_MIN));
    dir_table.push_back(typed_row(MODE_COMPUTE, 6'd0, 6'd0, '0,
                                  make_result(SAT_MAX, 1'b0, 1'b1)));
    // one negative lsb floors to minus one lsb
    dir_table.push_back(word_row(MODE_WRITE_A, 6'd0, 6'd0, 32'hFFFF_FFFF));
    dir_table.push_back(word_row(MODE_WRITE_B, 6'd0, 6'd0, 32'sd1));
    dir_table.push_back(typed_row(MODE_COMPUTE, 6'd0, 6'd0, '0,
                                  make_result(32'hFFFF_FFFF, 1'b0, 1'b0)));
    dir_table.push_back(word_row(MODE_WRITE_A, 6'd0, 6'd0, 32'sh0001_0000));
    dir_table.push_back(word_row(MODE_WRITE_B, 6'd0, 6'd0, 32'sh0001_0000));
    dir_table.push_back(typed_row(MODE_COMPUTE, 6'd0, 6'd0, SAT_MAX,
                                  make_result(32'sh0001_0000, 1'b0, 1'b0)));
    // out of range on every dimension of every mode
    dir_table.push_back(typed_row(MODE_WRITE_A, 6'd63, 6'd0, SAT_MAX,
                                  make_result('0, 1'b1, 1'b0)));
    dir_table.push_back(typed_row(MODE_WRITE_A, 6'd0, 6'd2, SAT_MIN,
                                  make_result('0, 1'b1, 1'b0)));
    dir_table.push_back(typed_row(MODE_WRITE_B, 6'd2, 6'd0, SAT_MAX,
                                  make_result('0, 1'b1, 1'b0)));
    dir_table.push_back(typed_row(MODE_WRITE_B, 6'd0, 6'd63, SAT_MIN,
                                  make_result('0, 1'b1, 1'b0)));
    dir_table.push_back(typed_row(MODE_COMPUTE, 6'd63, 6'd1, '0,
                                  make_result('0, 1'b1, 1'b0)));
    dir_table.push_back(typed_row(MODE_COMPUTE, 6'd1, 6'd2, '0,
                                  make_result('0, 1'b1, 1'b0)));
    dir_table.push_back(word_row(MODE_SPARE, 6'd63, 6'd63, 32'hFFFF_FFFF));
    dir_table.push_back(word_row(MODE_WRITE_A, 6'd1, 6'd0, 32'sh0001_8000));
    dir_table.push_back(word_row(MODE_WRITE_A, 6'd1, 6'd1, 32'shFFFE_0000));
    dir_table.push_back(word_row(MODE_WRITE_B, 6'd0, 6'd1, 32'sh0002_0000));
    dir_table.push_back(word_row(MODE_WRITE_B, 6'd1, 6'd1, 32'sh0000_8000));
    dir_table.push_back(word_row(MODE_COMPUTE, 6'd1, 6'd1, '0));
    dir_table.push_back(word_row(MODE_COMPUTE, 6'd0, 6'd1, '0));
    dir_table.push_back(word_row(MODE_COMPUTE, 6'd1, 6'd0, '0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_SIZES) begin
        wait_drained();
        set_sizes(dir_table[i].rows, dir_table[i].inner, dir_table[i].cols);
      end else begin
        send_word(dir_table[i].mode, dir_table[i].row, dir_table[i].col, dir_table[i].value,
                  dir_table[i].typed, dir_table[i].want);
      end
    end

    phase = 0;
    while (words_sent < RANDOM_WORDS + dir_table.size()) begin
      r = CFG_W'($urandom_range(1, 6));
      k = CFG_W'($urandom_range(1, 6));
      c = CFG_W'($urandom_range(1, 6));
      sel = $urandom_range(0, 11);
      if (sel == 0) begin
        r = pick_big();
        k = pick_big();
        c = pick_big();
      end else if (sel == 1) begin
        case ($urandom_range(0, 2))
          0: r = '0;
          1: k = '0;
          default: c = '0;
        endcase
      end else if (sel == 2) begin
        case ($urandom_range(0, 2))
          0: r = pick_big();
          1: k = pick_big();
          default: c = pick_big();
        endcase
      end
      wait_drained();
      // the unused register index must be ignored
      if (phase == 0) cfg_write(CFG_SPARE, 7'h7F);
      set_sizes(r, k, c);
      sender_steady = ($urandom_range(0, 4) == 0);
      big = (r > 8) || (k > 8) || (c > 8);
      actions = big ? $urandom_range(2, 5) : $urandom_range(15, 50);
      for (int i = 0; i < actions; i++) begin
        nr = dim_limit(rows_sz);
        nk = dim_limit(inner_sz);
        nc = dim_limit(cols_sz);
        pick = $urandom_range(0, 99);
        if (pick < 3) wait_drained();
        if (pick < 45 && nr != 0 && nc != 0) begin
          request_product(IDX_W'($urandom_range(0, nr - 1)), IDX_W'($urandom_range(0, nc - 1)));
        end else if (pick < 58 && nr != 0 && nk != 0) begin
          send_word(MODE_WRITE_A, IDX_W'($urandom_range(0, nr - 1)),
                    IDX_W'($urandom_range(0, nk - 1)), pick_value(), 1'b0, '0);
        end else if (pick < 70 && nk != 0 && nc != 0) begin
          send_word(MODE_WRITE_B, IDX_W'($urandom_range(0, nk - 1)),
                    IDX_W'($urandom_range(0, nc - 1)), pick_value(), 1'b0, '0);
        end else if (pick < 93) begin
          m = MODE_W'($urandom_range(0, 3));
          if (m == MODE_COMPUTE) request_product(IDX_W'($urandom), IDX_W'($urandom));
          else send_word(m, IDX_W'($urandom), IDX_W'($urandom), pick_value(), 1'b0, '0);
        end else begin
          send_word(MODE_SPARE, IDX_W'($urandom), IDX_W'($urandom), $urandom, 1'b0, '0);
        end
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d words over %0d size settings (%0d register writes)",
             words_sent, phase + 1, size_writes);
    $display("checked %0d result words: %0d saturated, %0d index errors",
             results_checked, sat_seen, err_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
